FILE: src/bfea_pkg.sv
`timescale 1ns / 1ps
package bfea_pkg;

  localparam int MaxExtents = 64;
  localparam int HoleSlots  = MaxExtents + 1;
  localparam int IdxW       = $clog2(HoleSlots + 1);
  localparam int CntW       = $clog2(MaxExtents + 1);
  localparam int AddrW      = 16;
  localparam int LenW       = 32;
  localparam int EntryW     = 2 * LenW;
  localparam logic [AddrW-1:0] TotalReset = AddrW'(1024);

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StBad     = 2'd3;

  localparam logic FuncAlloc = 1'b0;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_MAX,
    S_DONE
  } state_e;

  typedef struct packed {
    logic init_wr;
    logic load;
    logic check;
    logic scan;
    logic decide;
    logic shift;
    logic sweep_max;
  } cmd_t;

  typedef struct packed {
    logic pre_bad;
    logic at_end;
    logic remove;
  } sts_t;

endpackage

FILE: src/bfea_ram.sv
`timescale 1ns / 1ps
module bfea_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bfea_ctrl.sv
`timescale 1ns / 1ps
module bfea_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  bfea_pkg::sts_t sts_i,
  output bfea_pkg::cmd_t cmd_o,
  output logic           busy,
  output logic           done_o
);

  bfea_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfea_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfea_pkg::S_INIT:   state_d = bfea_pkg::S_IDLE;
      bfea_pkg::S_IDLE:   if (start) state_d = bfea_pkg::S_CHECK;
      bfea_pkg::S_CHECK:  state_d = sts_i.pre_bad ? bfea_pkg::S_MAX : bfea_pkg::S_SCAN;
      bfea_pkg::S_SCAN:   if (sts_i.at_end) state_d = bfea_pkg::S_DECIDE;
      bfea_pkg::S_DECIDE: state_d = sts_i.remove ? bfea_pkg::S_SHIFT : bfea_pkg::S_MAX;
      bfea_pkg::S_SHIFT:  if (sts_i.at_end) state_d = bfea_pkg::S_MAX;
      bfea_pkg::S_MAX:    if (sts_i.at_end) state_d = bfea_pkg::S_DONE;
      bfea_pkg::S_DONE:   state_d = bfea_pkg::S_IDLE;
      default:            state_d = bfea_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      bfea_pkg::S_INIT:   cmd_o.init_wr   = 1'b1;
      bfea_pkg::S_IDLE:   cmd_o.load      = start;
      bfea_pkg::S_CHECK:  cmd_o.check     = 1'b1;
      bfea_pkg::S_SCAN:   cmd_o.scan      = 1'b1;
      bfea_pkg::S_DECIDE: cmd_o.decide    = 1'b1;
      bfea_pkg::S_SHIFT:  cmd_o.shift     = 1'b1;
      bfea_pkg::S_MAX:    cmd_o.sweep_max = 1'b1;
      default:            cmd_o = '0;
    endcase
  end

  assign busy   = (state_q != bfea_pkg::S_IDLE);
  assign done_o = (state_q == bfea_pkg::S_DONE);

endmodule

FILE: src/bfea_dp.sv
`timescale 1ns / 1ps
module bfea_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfea_pkg::cmd_t              cmd_i,
  output bfea_pkg::sts_t              sts_o,
  input  logic                        cfg_we_i,
  input  logic [bfea_pkg::AddrW-1:0]  cfg_wdata_i,
  input  logic                        func_i,
  input  logic [bfea_pkg::AddrW-1:0]  block_count_i,
  input  logic [bfea_pkg::AddrW-1:0]  first_block_i,
  output logic [1:0]                  status_o,
  output logic [bfea_pkg::AddrW-1:0]  alloc_start_o,
  output logic [bfea_pkg::AddrW-1:0]  largest_hole_o,
  output logic [bfea_pkg::IdxW-1:0]   holes_in_table_o,
  output logic [bfea_pkg::CntW-1:0]   extents_in_use_o
);

  localparam int LenW = bfea_pkg::LenW;
  localparam int IdxW = bfea_pkg::IdxW;
  localparam int AddrW = bfea_pkg::AddrW;
  localparam int RamAw = $clog2(bfea_pkg::HoleSlots);

  logic [AddrW-1:0] total_q;
  logic [IdxW-1:0]  ht_q;
  logic [bfea_pkg::CntW-1:0] et_q;
  logic             func_q;
  logic [AddrW-1:0] cnt_q, first_q;
  logic [IdxW-1:0]  idx_q, rd_idx_q;
  logic             rd_vld_q;
  logic             found_q, has_p_q, has_n_q;
  logic [IdxW-1:0]  pick_q, p_q, n_q;
  logic [LenW-1:0]  pick_s_q, pick_l_q, p_s_q, p_l_q, n_l_q, max_q;
  logic [1:0]       status_q;
  logic [AddrW-1:0] start_q;

  logic                         ram_we;
  logic [RamAw-1:0]             ram_waddr;
  logic [bfea_pkg::EntryW-1:0]  ram_wdata, ram_rdata;
  logic [LenW-1:0]              rd_s, rd_l;

  logic             sweeping, issue, at_end;
  logic [AddrW:0]   end_w;
  logic [LenW-1:0]  cnt_w, end_l, first_l, new_l;
  logic [AddrW-1:0] cfg_total;
  logic             pre_bad, remove, is_alloc;

  assign is_alloc  = (func_q == bfea_pkg::FuncAlloc);
  assign rd_s      = ram_rdata[2*LenW-1:LenW];
  assign rd_l      = ram_rdata[LenW-1:0];
  assign cnt_w     = LenW'(cnt_q);
  assign first_l   = LenW'(first_q);
  assign end_w     = {1'b0, first_q} + {1'b0, cnt_q};
  assign end_l     = LenW'(end_w);
  assign new_l     = pick_l_q - cnt_w;
  assign cfg_total = (cfg_wdata_i == '0) ? AddrW'(1) : cfg_wdata_i;

  assign at_end   = (idx_q >= ht_q);
  assign sweeping = cmd_i.scan | cmd_i.shift | cmd_i.sweep_max;
  assign issue    = sweeping & ~at_end;

  always_comb begin
    if (is_alloc) begin
      pre_bad = (cnt_q == '0) || (et_q >= bfea_pkg::CntW'(bfea_pkg::MaxExtents));
      remove  = found_q && (new_l == '0);
    end else begin
      pre_bad = (cnt_q == '0) || (end_w > {1'b0, total_q}) || (et_q == '0);
      remove  = has_p_q && has_n_q;
    end
  end

  assign sts_o.pre_bad = pre_bad;
  assign sts_o.at_end  = at_end;
  assign sts_o.remove  = remove;

  // One write port: configuration, start-up, the decision write and the shift down.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cfg_we_i) begin
      ram_we    = 1'b1;
      ram_wdata = {LenW'(0), LenW'(cfg_total)};
    end else if (cmd_i.init_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {LenW'(0), LenW'(total_q)};
    end else if (cmd_i.decide) begin
      if (is_alloc) begin
        ram_we    = found_q && (new_l != '0);
        ram_waddr = RamAw'(pick_q);
        ram_wdata = {pick_s_q + cnt_w, new_l};
      end else if (has_p_q) begin
        ram_we    = 1'b1;
        ram_waddr = RamAw'(p_q);
        ram_wdata = {p_s_q, p_l_q + cnt_w + (has_n_q ? n_l_q : LenW'(0))};
      end else if (has_n_q) begin
        ram_we    = 1'b1;
        ram_waddr = RamAw'(n_q);
        ram_wdata = {first_l, n_l_q + cnt_w};
      end else begin
        ram_we    = (ht_q < IdxW'(bfea_pkg::HoleSlots));
        ram_waddr = RamAw'(ht_q);
        ram_wdata = {first_l, cnt_w};
      end
    end else if (cmd_i.shift && rd_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = RamAw'(rd_idx_q - IdxW'(1));
      ram_wdata = ram_rdata;
    end
  end

  bfea_ram #(
    .Width(bfea_pkg::EntryW),
    .Depth(bfea_pkg::HoleSlots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(RamAw'(idx_q)),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= bfea_pkg::TotalReset;
      ht_q     <= IdxW'(1);
      et_q     <= '0;
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cfg_we_i) begin
        total_q <= cfg_total;
        ht_q    <= IdxW'(1);
        et_q    <= '0;
      end
      if (cmd_i.check) begin
        idx_q <= '0;
      end
      if (cmd_i.decide) begin
        idx_q <= remove ? (has_n_q && !is_alloc ? n_q : pick_q) + IdxW'(1) : '0;
        if (is_alloc) begin
          if (found_q) begin
            et_q <= et_q + bfea_pkg::CntW'(1);
          end
        end else if (has_p_q || has_n_q || ht_q < IdxW'(bfea_pkg::HoleSlots)) begin
          et_q <= et_q - bfea_pkg::CntW'(1);
          if (!has_p_q && !has_n_q) begin
            ht_q <= ht_q + IdxW'(1);
          end
        end
      end
      if (cmd_i.shift && at_end) begin
        ht_q  <= ht_q - IdxW'(1);
        idx_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_i.load) begin
      func_q  <= func_i;
      cnt_q   <= block_count_i;
      first_q <= first_block_i;
    end
    if (cmd_i.check) begin
      found_q  <= 1'b0;
      has_p_q  <= 1'b0;
      has_n_q  <= 1'b0;
      max_q    <= '0;
      start_q  <= '0;
      status_q <= bfea_pkg::StOk;
      if (pre_bad) begin
        status_q <= (is_alloc && cnt_q != '0) ? bfea_pkg::StFull : bfea_pkg::StBad;
      end
    end
    if (cmd_i.scan && rd_vld_q) begin
      if (rd_l >= cnt_w && (!found_q || rd_l < pick_l_q)) begin
        found_q  <= 1'b1;
        pick_q   <= rd_idx_q;
        pick_s_q <= rd_s;
        pick_l_q <= rd_l;
      end
      if (!has_n_q && rd_s == end_l) begin
        has_n_q <= 1'b1;
        n_q     <= rd_idx_q;
        n_l_q   <= rd_l;
      end
      if (!has_p_q && (rd_s + rd_l) == first_l) begin
        has_p_q <= 1'b1;
        p_q     <= rd_idx_q;
        p_s_q   <= rd_s;
        p_l_q   <= rd_l;
      end
    end
    if (cmd_i.decide) begin
      max_q <= '0;
      if (is_alloc) begin
        if (found_q) begin
          start_q <= AddrW'(pick_s_q);
        end else begin
          status_q <= bfea_pkg::StNoSpace;
        end
      end else if (has_p_q) begin
        start_q <= AddrW'(p_s_q);
      end else if (has_n_q || ht_q < IdxW'(bfea_pkg::HoleSlots)) begin
        start_q <= first_q;
      end else begin
        status_q <= bfea_pkg::StFull;
      end
    end
    if (cmd_i.sweep_max && rd_vld_q && rd_l > max_q) begin
      max_q <= rd_l;
    end
  end

  assign status_o         = status_q;
  assign alloc_start_o    = start_q;
  assign largest_hole_o   = max_q[AddrW-1:0];
  assign holes_in_table_o = ht_q;
  assign extents_in_use_o = et_q;

endmodule

FILE: src/best_fit_extent_allocator.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake           | Payload
// request   | in        | start, busy         | func_i, block_count_i, first_block_i
// result    | out       | done_o (one cycle)  | status_o, alloc_start_o, largest_hole_o,
//           |           |                     | holes_in_table_o, extents_in_use_o
// config    | in        | cfg_we_i            | cfg_wdata_i (total_blocks)
//
// A taken request is checked; a scan pass finds the best fit or the neighbouring holes,
// the decision writes the table, a shift pass closes the gap when a hole is removed and a
// last pass finds the largest hole; a request refused at the check goes straight to it.
// Each pass reads one hole entry a cycle through the RAM port. busy is low only in idle,
// after the result, until a request is taken. After reset the block is busy for one cycle
// while it writes the initial hole. Results stay registered; done_o cannot be stalled.
module best_fit_extent_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func_i,
  input  logic [bfea_pkg::AddrW-1:0] block_count_i,
  input  logic [bfea_pkg::AddrW-1:0] first_block_i,
  input  logic                       cfg_we_i,
  input  logic [bfea_pkg::AddrW-1:0] cfg_wdata_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [bfea_pkg::AddrW-1:0] alloc_start_o,
  output logic [bfea_pkg::AddrW-1:0] largest_hole_o,
  output logic [bfea_pkg::IdxW-1:0]  holes_in_table_o,
  output logic [bfea_pkg::CntW-1:0]  extents_in_use_o
);

  bfea_pkg::cmd_t cmd;
  bfea_pkg::sts_t sts;

  bfea_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy  (busy),
    .done_o(done_o)
  );

  bfea_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .block_count_i   (block_count_i),
    .first_block_i   (first_block_i),
    .status_o        (status_o),
    .alloc_start_o   (alloc_start_o),
    .largest_hole_o  (largest_hole_o),
    .holes_in_table_o(holes_in_table_o),
    .extents_in_use_o(extents_in_use_o)
  );

endmodule

FILE: dv/tb_best_fit_extent_allocator.sv
`timescale 1ns / 1ps
module tb_best_fit_extent_allocator;

  localparam int SettleCycles = 400;
  localparam int CycleLimit   = 3000000;

  typedef struct {
    logic [1:0]                 status;
    logic [bfea_pkg::AddrW-1:0] start_blk;
    logic [bfea_pkg::AddrW-1:0] largest;
    logic [bfea_pkg::IdxW-1:0]  holes;
    logic [bfea_pkg::CntW-1:0]  extents;
  } outcome_t;

  typedef struct {
    logic [bfea_pkg::AddrW-1:0] first;
    logic [bfea_pkg::AddrW-1:0] count;
  } extent_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       func_i = 1'b0;
  logic [bfea_pkg::AddrW-1:0] block_count_i = '0;
  logic [bfea_pkg::AddrW-1:0] first_block_i = '0;
  logic                       cfg_we_i = 1'b0;
  logic [bfea_pkg::AddrW-1:0] cfg_wdata_i = '0;
  logic                       done_o;
  logic [1:0]                 status_o;
  logic [bfea_pkg::AddrW-1:0] alloc_start_o;
  logic [bfea_pkg::AddrW-1:0] largest_hole_o;
  logic [bfea_pkg::IdxW-1:0]  holes_in_table_o;
  logic [bfea_pkg::CntW-1:0]  extents_in_use_o;

  best_fit_extent_allocator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .block_count_i    (block_count_i),
    .first_block_i    (first_block_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .alloc_start_o    (alloc_start_o),
    .largest_hole_o   (largest_hole_o),
    .holes_in_table_o (holes_in_table_o),
    .extents_in_use_o (extents_in_use_o)
  );

  always #6 clk_i = ~clk_i;

  // Free-space model: compact hole table in the same order as the block keeps it.
  int unsigned disk_blocks;
  int unsigned hole_base[bfea_pkg::HoleSlots];
  int unsigned hole_len[bfea_pkg::HoleSlots];
  int unsigned hole_cnt;
  int unsigned extent_cnt;

  outcome_t expected_q[$];
  extent_t  live_q[$];
  int       idle_pct;
  int       error_count;
  int       request_count;
  int       config_count;
  int       cycle_count = 0;

  function automatic void reset_table(input int unsigned blocks);
    disk_blocks = (blocks == 0) ? 1 : blocks;
    for (int i = 0; i < bfea_pkg::HoleSlots; i++) begin
      hole_base[i] = 0;
      hole_len[i]  = 0;
    end
    hole_len[0] = disk_blocks;
    hole_cnt    = 1;
    extent_cnt  = 0;
  endfunction

  function automatic void drop_hole(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < hole_cnt; i++) begin
      hole_base[i] = hole_base[i+1];
      hole_len[i]  = hole_len[i+1];
    end
    hole_cnt--;
    hole_base[hole_cnt] = 0;
    hole_len[hole_cnt]  = 0;
  endfunction

  function automatic outcome_t predict_request(input logic f, input int unsigned cnt,
                                               input int unsigned first);
    outcome_t    res;
    int unsigned pick, prv, nxt, finish, best;
    bit          found, has_prv, has_nxt;
    res.status = bfea_pkg::StOk;
    res.start_blk = '0;
    pick = 0; prv = 0; nxt = 0; found = 0; has_prv = 0; has_nxt = 0;
    finish = first + cnt;
    if (f == bfea_pkg::FuncAlloc) begin
      if (cnt == 0) res.status = bfea_pkg::StBad;
      else if (extent_cnt >= bfea_pkg::MaxExtents) res.status = bfea_pkg::StFull;
      else begin
        for (int unsigned i = 0; i < hole_cnt; i++)
          if (hole_len[i] >= cnt && (!found || hole_len[i] < hole_len[pick])) begin
            pick = i;
            found = 1;
          end
        if (!found) res.status = bfea_pkg::StNoSpace;
        else begin
          res.start_blk = hole_base[pick][bfea_pkg::AddrW-1:0];
          hole_base[pick] += cnt;
          hole_len[pick]  -= cnt;
          if (hole_len[pick] == 0) drop_hole(pick);
          extent_cnt++;
        end
      end
    end else begin
      if (cnt == 0 || finish > disk_blocks || extent_cnt == 0) res.status = bfea_pkg::StBad;
      else begin
        for (int unsigned i = 0; i < hole_cnt; i++) begin
          if (!has_nxt && hole_base[i] == finish) begin
            nxt = i;
            has_nxt = 1;
          end
          if (!has_prv && hole_base[i] + hole_len[i] == first) begin
            prv = i;
            has_prv = 1;
          end
        end
        if (has_prv && has_nxt) begin
          hole_len[prv] += cnt + hole_len[nxt];
          res.start_blk = hole_base[prv][bfea_pkg::AddrW-1:0];
          drop_hole(nxt);
        end else if (has_prv) begin
          hole_len[prv] += cnt;
          res.start_blk = hole_base[prv][bfea_pkg::AddrW-1:0];
        end else if (has_nxt) begin
          hole_base[nxt] = first;
          hole_len[nxt] += cnt;
          res.start_blk = first[bfea_pkg::AddrW-1:0];
        end else if (hole_cnt >= bfea_pkg::HoleSlots) begin
          res.status = bfea_pkg::StFull;
        end else begin
          hole_base[hole_cnt] = first;
          hole_len[hole_cnt]  = cnt;
          hole_cnt++;
          res.start_blk = first[bfea_pkg::AddrW-1:0];
        end
        if (res.status == bfea_pkg::StOk) extent_cnt--;
      end
    end
    best = 0;
    for (int unsigned i = 0; i < hole_cnt; i++)
      if (hole_len[i] > best) best = hole_len[i];
    res.largest = best[bfea_pkg::AddrW-1:0];
    res.holes   = hole_cnt[bfea_pkg::IdxW-1:0];
    res.extents = extent_cnt[bfea_pkg::CntW-1:0];
    return res;
  endfunction

  // Holds start high until a transaction is taken; busy is sampled at the falling
  // edge, where it is stable for the following rising edge.
  task automatic issue_request(input logic f, input logic [bfea_pkg::AddrW-1:0] cnt,
                               input logic [bfea_pkg::AddrW-1:0] first, output outcome_t res);
    bit took;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= f;
    block_count_i <= cnt;
    first_block_i <= first;
    do begin
      @(negedge clk_i);
      took = !busy;
      @(posedge clk_i);
    end while (!took);
    res = predict_request(f, cnt, first);
    expected_q.insert(expected_q.size(), res);
    request_count++;
  endtask

  task automatic write_disk_size(input logic [bfea_pkg::AddrW-1:0] blocks);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= blocks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reset_table(blocks);
    live_q.delete();
    config_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    outcome_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction, status %0d", $time, status_o);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("status", exp_r.status, status_o);
        check_field("alloc_start", exp_r.start_blk, alloc_start_o);
        check_field("largest_hole", exp_r.largest, largest_hole_o);
        check_field("holes_in_table", exp_r.holes, holes_in_table_o);
        check_field("extents_in_use", exp_r.extents, extents_in_use_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_best_fit_extent_allocator NOT OK");
      $finish;
    end
  end

  task automatic test_refusals();
    outcome_t r;
    write_disk_size(16'd1024);
    issue_request(bfea_pkg::FuncAlloc, 16'd0, 16'd0, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd10, 16'd5, r);
    issue_request(bfea_pkg::FuncAlloc, 16'hFFFF, 16'hFFFF, r);
    issue_request(bfea_pkg::FuncAlloc, 16'd1024, 16'd0, r);
    issue_request(bfea_pkg::FuncAlloc, 16'd1, 16'd0, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd0, 16'd0, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd100, 16'd1000, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'hFFFF, 16'hFFFF, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd1024, 16'd0, r);
  endtask

  // Frees extents next to existing holes so that merging and the smallest-fit rule show.
  task automatic test_best_fit_and_merge();
    outcome_t r;
    write_disk_size(16'd1000);
    issue_request(bfea_pkg::FuncAlloc, 16'd100, 16'd0, r);
    issue_request(bfea_pkg::FuncAlloc, 16'd50, 16'd0, r);
    issue_request(bfea_pkg::FuncAlloc, 16'd200, 16'd0, r);
    issue_request(bfea_pkg::FuncAlloc, 16'd50, 16'd0, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd100, 16'd0, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd50, 16'd350, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd50, 16'd100, r);
    issue_request(bfea_pkg::FuncAlloc, 16'd40, 16'd0, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd40, 16'd150, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd200, 16'd150, r);
  endtask

  task automatic test_table_limits();
    outcome_t r;
    write_disk_size(16'd1000);
    for (int i = 0; i < bfea_pkg::MaxExtents; i++)
      issue_request(bfea_pkg::FuncAlloc, 16'd1, 16'd0, r);
    issue_request(bfea_pkg::FuncAlloc, 16'd1, 16'd0, r);
    // Isolated single blocks well inside the big hole each open a new hole.
    for (int i = 0; i < bfea_pkg::MaxExtents; i++)
      issue_request(~bfea_pkg::FuncAlloc, 16'd1, 16'(200 + 2 * i), r);
    issue_request(bfea_pkg::FuncAlloc, 16'd2, 16'd0, r);
    issue_request(~bfea_pkg::FuncAlloc, 16'd1, 16'd500, r);
  endtask

  task automatic test_random(input logic [bfea_pkg::AddrW-1:0] blocks, input int items);
    outcome_t    r;
    extent_t     e;
    int unsigned sel, idx, cnt;
    write_disk_size(blocks);
    for (int n = 0; n < items; n++) begin
      idle_pct = (n < items / 4) ? 0 : (n < items / 2) ? 52 : (n < 3 * items / 4) ? 0 : 19;
      sel = $urandom_range(99);
      if (sel < 45) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(1, disk_blocks)
                                      : $urandom_range(1, 16);
        issue_request(bfea_pkg::FuncAlloc, 16'(cnt), 16'($urandom()), r);
        if (r.status == bfea_pkg::StOk) begin
          e.first = r.start_blk;
          e.count = 16'(cnt);
          live_q.insert(live_q.size(), e);
        end
      end else if (sel < 88 && live_q.size() != 0) begin
        idx = $urandom_range(live_q.size() - 1);
        e = live_q[idx];
        live_q.delete(idx);
        issue_request(~bfea_pkg::FuncAlloc, e.count, e.first, r);
      end else begin
        cnt = ($urandom_range(3) == 0) ? 0 : $urandom_range(16'hFFFF);
        issue_request(1'($urandom()), 16'(cnt), 16'($urandom()), r);
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    error_count = 0;
    request_count = 0;
    config_count = 0;
    idle_pct = 0;
    reset_table(bfea_pkg::TotalReset);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_refusals();
    test_best_fit_and_merge();
    test_table_limits();
    test_random(16'd0, 30);
    test_random(16'hFFFF, 90);
    test_random(16'd200, 110);
    test_random(16'($urandom_range(17, 4000)), 90);
    test_random(16'd40, 80);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d requests over %0d disk sizes: refusals, best fit, merging,",
             request_count, config_count);
    $display("full extent and hole tables, and random allocate/free traffic with idling.");
    if (error_count == 0) begin
      $display("tb_best_fit_extent_allocator OK");
    end else begin
      $display("tb_best_fit_extent_allocator NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
src/bfea_pkg.sv
src/bfea_ram.sv
src/bfea_ctrl.sv
src/bfea_dp.sv
src/best_fit_extent_allocator.sv
dv/tb_best_fit_extent_allocator.sv
